[src/mbed_pkg.sv]
// ----------------------------------------------------------------------------
// mbed_pkg - shared types and constants of the multi-button event detector
// Button stages, event codes, register indexes and the timing bundle
// handed from the register file to the button engine.
// ----------------------------------------------------------------------------
package mbed_pkg;

    // Default sizing of the block
    localparam int NUM_BUTTONS_DEF = 8;
    localparam int COUNT_WIDTH_DEF = 16;

    // Depth of the tick queue between front and back
    localparam int Q_DEPTH = 2;

    // Field widths fixed by the interface
    localparam int LEVEL_W = 8;
    localparam int TICKS_W = 16;
    localparam int CLICK_W = 8;

    // Register indexes (byte address bits [4:2])
    localparam logic [2:0] REG_ACTIVE_LEVELS = 3'd0;
    localparam logic [2:0] REG_BUTTON_COUNT  = 3'd1;
    localparam logic [2:0] REG_SHORT_TICKS   = 3'd2;
    localparam logic [2:0] REG_LONG_TICKS    = 3'd3;
    localparam logic [2:0] REG_GAP_TICKS     = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_DOWN  = 2'd1,
        ST_MULTI = 2'd2
    } t_stage;

    typedef enum logic [3:0] {
        EV_NONE        = 4'd0,
        EV_DOWN        = 4'd1,
        EV_CLICK       = 4'd2,
        EV_DOUBLE      = 4'd3,
        EV_REPEAT      = 4'd4,
        EV_SHORT_START = 4'd5,
        EV_SHORT_UP    = 4'd6,
        EV_LONG_START  = 4'd7,
        EV_LONG_UP     = 4'd8
    } t_event;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_RUN  = 1'b1
    } t_back_state;

    typedef struct packed {
        logic [TICKS_W-1:0] short_ticks;
        logic [TICKS_W-1:0] long_ticks;
        logic [TICKS_W-1:0] gap_ticks;
    } t_timing;

    // Map a click total onto its event
    function automatic t_event click_code(input logic [CLICK_W-1:0] clicks);
        t_event ev;
        if (clicks >= CLICK_W'(3)) begin
            ev = EV_REPEAT;
        end else if (clicks == CLICK_W'(2)) begin
            ev = EV_DOUBLE;
        end else begin
            ev = EV_CLICK;
        end
        return ev;
    endfunction

endpackage

[src/mbed_front.sv]
// ----------------------------------------------------------------------------
// mbed_front - scan tick intake
// Accepts raw level transactions, works out which buttons are pressed and
// how many are enabled, and queues a tick job for the engine. A tick with
// no enabled buttons is taken and dropped.
// ----------------------------------------------------------------------------
module mbed_front
    import mbed_pkg::*;
#(
    parameter int NW = 4
) (
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [LEVEL_W-1:0] i_raw_levels,
    input  logic [LEVEL_W-1:0] i_active_levels,
    input  logic [NW-1:0]      i_enabled,
    input  logic               i_q_full,
    output logic               o_push,
    output logic [LEVEL_W-1:0] o_push_hit,
    output logic [NW-1:0]      o_push_n
);

    // Hold the source while the queue has no room
    assign o_stall = i_q_full;

    // Pressed where the raw level matches the active level
    assign o_push_hit = ~(i_raw_levels ^ i_active_levels);
    assign o_push_n   = i_enabled;

    // Queue only ticks that produce results
    assign o_push = i_valid && !i_q_full && (i_enabled != '0);

endmodule

[src/mbed_queue.sv]
// ----------------------------------------------------------------------------
// mbed_queue - short tick job queue
// Small register queue that decouples the intake from the button engine.
// ----------------------------------------------------------------------------
module mbed_queue
    import mbed_pkg::*;
#(
    parameter int WIDTH = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [Q_DEPTH];
    logic [PW-1:0]    r_wptr;
    logic [PW-1:0]    r_rptr;
    logic [CW-1:0]    r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CW'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Store incoming jobs
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= PW'(r_wptr + 1'b1);
            end
            if (do_pop) begin
                r_rptr <= PW'(r_rptr + 1'b1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= CW'(r_cnt + 1'b1);
            end else if (do_pop && !do_push) begin
                r_cnt <= CW'(r_cnt - 1'b1);
            end
        end
    end

endmodule

[src/mbed_back.sv]
// ----------------------------------------------------------------------------
// mbed_back - button engine
// Takes one tick job at a time and steps the enabled buttons from the
// highest index down into an output register, one per cycle while it has room.
// ----------------------------------------------------------------------------
module mbed_back
    import mbed_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    parameter int NW          = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_timing            i_timing,
    input  logic               i_clr,
    input  logic [NW-1:0]      i_clr_from,
    input  logic               i_q_empty,
    input  logic [LEVEL_W-1:0] i_job_hit,
    input  logic [NW-1:0]      i_job_n,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [2:0]         o_button_index,
    output logic [3:0]         o_event_code,
    output logic               o_event_fired,
    output logic [3:0]         o_active_count,
    output logic               o_last
);

    localparam int IW  = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int EXT = (COUNT_WIDTH > TICKS_W) ? COUNT_WIDTH : TICKS_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_TOP_M1 = {{(COUNT_WIDTH-1){1'b1}}, 1'b0};

    typedef logic [EXT-1:0] t_ext;

    // Per-button state
    t_stage                 r_stage  [NUM_BUTTONS];
    logic [COUNT_WIDTH-1:0] r_tick   [NUM_BUTTONS];
    logic [CLICK_W-1:0]     r_clicks [NUM_BUTTONS];
    t_event                 r_event  [NUM_BUTTONS];

    // Sequencer
    t_back_state        r_state;
    t_back_state        n_state;
    logic [IW-1:0]      r_idx;
    logic [LEVEL_W-1:0] r_hit;
    logic [NW-1:0]      r_active;
    logic               step;

    // Output register
    logic         r_out_valid;
    logic [2:0]   r_out_index;
    t_event       r_out_event;
    logic         r_out_fired;
    logic [3:0]   r_out_active;
    logic         r_out_last;

    // Step results
    t_stage                 n_stage;
    logic [COUNT_WIDTH-1:0] n_tick;
    logic [CLICK_W-1:0]     n_clicks;
    t_event                 n_event;
    logic                   n_fired;
    logic [NW-1:0]          n_active;
    logic                   pressed;
    logic [COUNT_WIDTH-1:0] tick_inc;
    logic [COUNT_WIDTH-1:0] reload;

    // Sequence jobs and gate each step on output room
    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        step    = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    n_state = BK_RUN;
                end
            end
            BK_RUN: begin
                step = !r_out_valid || !i_stall;
                if (step && (r_idx == '0)) begin
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Load a job, walk the buttons downwards, total the active ones
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_idx    <= IW'(i_job_n - 1'b1);
            r_hit    <= i_job_hit;
            r_active <= '0;
        end else if (step) begin
            r_idx    <= IW'(r_idx - 1'b1);
            r_active <= n_active;
        end
    end

    // Run one tick of the selected button
    always_comb begin
        n_stage  = r_stage[r_idx];
        n_clicks = r_clicks[r_idx];
        n_event  = r_event[r_idx];
        n_fired  = 1'b0;
        n_tick   = r_tick[r_idx];
        pressed  = (32'(r_idx) < 32'd8) && r_hit[3'(r_idx)];
        reload   = (t_ext'(i_timing.long_ticks) < t_ext'(CNT_TOP_M1)) ?
                   COUNT_WIDTH'(i_timing.long_ticks) : CNT_TOP_M1;
        tick_inc = COUNT_WIDTH'(r_tick[r_idx] + 1'b1);

        // Count up while busy, fold back from the top
        if (r_stage[r_idx] != ST_IDLE) begin
            n_tick = (tick_inc == '1) ? reload : tick_inc;
        end

        case (r_stage[r_idx])
            ST_IDLE: begin
                if (pressed) begin
                    n_tick   = '0;
                    n_clicks = '0;
                    n_event  = EV_DOWN;
                    n_fired  = 1'b1;
                    n_stage  = ST_DOWN;
                end else begin
                    n_event = EV_NONE;
                end
            end
            ST_DOWN: begin
                if (pressed) begin
                    if (r_clicks[r_idx] != '0) begin
                        // Held again after clicks: close the sequence on the gap
                        if (t_ext'(n_tick) > t_ext'(i_timing.gap_ticks)) begin
                            n_event  = click_code(r_clicks[r_idx]);
                            n_fired  = 1'b1;
                            n_tick   = '0;
                            n_clicks = '0;
                        end
                    end else if (t_ext'(n_tick) >= t_ext'(i_timing.long_ticks)) begin
                        if (r_event[r_idx] != EV_LONG_START) begin
                            n_event = EV_LONG_START;
                            n_fired = 1'b1;
                        end
                    end else if (t_ext'(n_tick) >= t_ext'(i_timing.short_ticks)) begin
                        if (r_event[r_idx] != EV_SHORT_START) begin
                            n_event = EV_SHORT_START;
                            n_fired = 1'b1;
                        end
                    end
                end else begin
                    if (t_ext'(n_tick) >= t_ext'(i_timing.long_ticks)) begin
                        n_event = EV_LONG_UP;
                        n_fired = 1'b1;
                        n_stage = ST_IDLE;
                    end else if (t_ext'(n_tick) >= t_ext'(i_timing.short_ticks)) begin
                        n_event = EV_SHORT_UP;
                        n_fired = 1'b1;
                        n_stage = ST_IDLE;
                    end else begin
                        n_stage = ST_MULTI;
                        if (r_clicks[r_idx] != '1) begin
                            n_clicks = CLICK_W'(r_clicks[r_idx] + 1'b1);
                        end
                    end
                end
            end
            default: begin
                if (pressed) begin
                    n_stage = ST_DOWN;
                    n_tick  = '0;
                end else if (t_ext'(n_tick) > t_ext'(i_timing.gap_ticks)) begin
                    n_event = click_code(r_clicks[r_idx]);
                    n_fired = 1'b1;
                    n_stage = ST_IDLE;
                end
            end
        endcase

        n_active = (n_stage != ST_IDLE) ? NW'(r_active + 1'b1) : r_active;
    end

    // Write back button state; drop disabled buttons to reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                r_stage[i]  <= ST_IDLE;
                r_tick[i]   <= '0;
                r_clicks[i] <= '0;
                r_event[i]  <= EV_NONE;
            end
        end else if (i_clr) begin
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                if (32'(i) >= 32'(i_clr_from)) begin
                    r_stage[i]  <= ST_IDLE;
                    r_tick[i]   <= '0;
                    r_clicks[i] <= '0;
                    r_event[i]  <= EV_NONE;
                end
            end
        end else if (step) begin
            r_stage[r_idx]  <= n_stage;
            r_tick[r_idx]   <= n_tick;
            r_clicks[r_idx] <= n_clicks;
            r_event[r_idx]  <= n_event;
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_index  <= 3'(r_idx);
            r_out_event  <= n_event;
            r_out_fired  <= n_fired;
            r_out_last   <= (r_idx == '0);
            r_out_active <= (r_idx == '0) ? 4'(n_active) : 4'd0;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_button_index = r_out_index;
    assign o_event_code   = 4'(r_out_event);
    assign o_event_fired  = r_out_fired;
    assign o_active_count = r_out_active;
    assign o_last         = r_out_last;

endmodule

[src/multi_button_event_detector.sv]
// ----------------------------------------------------------------------------
// multi_button_event_detector - click and long press detector for buttons
// Top level: register file, tick intake, job queue and button engine.
// ----------------------------------------------------------------------------
// Each input transaction is one scan tick carrying the raw level of every
// button; the block answers with one result transaction per enabled button,
// highest index first, the final one flagged last and carrying the number
// of buttons still busy. The button engine steps one button per cycle while
// the output is not stalled, and goes back to idle to pick up each next tick
// job. A two-entry queue between intake and engine lets up to two ticks wait
// while the engine works. The user must set timings and levels through the
// register port only while the block is idle; the block does not enforce
// this. Writing button_count resets every button at or above the new count.
// ----------------------------------------------------------------------------
module multi_button_event_detector
    import mbed_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // Scan tick input
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [LEVEL_W-1:0] i_raw_levels,
    // Result output
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_button_index,
    output logic [3:0]         o_event_code,
    output logic               o_event_fired,
    output logic [3:0]         o_active_count,
    output logic               o_last
);

    localparam int NW = $clog2(NUM_BUTTONS + 1);
    localparam int QW = NW + LEVEL_W;

    logic [LEVEL_W-1:0] r_active_levels;
    logic [3:0]         r_button_count;
    t_timing            r_timing;

    logic [2:0]         reg_idx;
    logic               cfg_wr;
    logic [NW-1:0]      enabled;
    logic [NW-1:0]      wr_enabled;

    logic               push;
    logic [LEVEL_W-1:0] push_hit;
    logic [NW-1:0]      push_n;
    logic [QW-1:0]      q_out;
    logic               q_full;
    logic               q_empty;
    logic               pop;

    // Register write decode
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Clamp the button count to what is built
    assign enabled = (32'(r_button_count) > 32'(NUM_BUTTONS)) ?
                     NW'(NUM_BUTTONS) : NW'(r_button_count);
    assign wr_enabled = (32'(pwdata[3:0]) > 32'(NUM_BUTTONS)) ?
                        NW'(NUM_BUTTONS) : NW'(pwdata[3:0]);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_levels      <= '0;
            r_button_count       <= '0;
            r_timing.short_ticks <= '0;
            r_timing.long_ticks  <= '0;
            r_timing.gap_ticks   <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_ACTIVE_LEVELS: r_active_levels      <= pwdata[LEVEL_W-1:0];
                REG_BUTTON_COUNT:  r_button_count       <= pwdata[3:0];
                REG_SHORT_TICKS:   r_timing.short_ticks <= pwdata[TICKS_W-1:0];
                REG_LONG_TICKS:    r_timing.long_ticks  <= pwdata[TICKS_W-1:0];
                REG_GAP_TICKS:     r_timing.gap_ticks   <= pwdata[TICKS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back
    always_comb begin
        case (reg_idx)
            REG_ACTIVE_LEVELS: prdata = 32'(r_active_levels);
            REG_BUTTON_COUNT:  prdata = 32'(r_button_count);
            REG_SHORT_TICKS:   prdata = 32'(r_timing.short_ticks);
            REG_LONG_TICKS:    prdata = 32'(r_timing.long_ticks);
            REG_GAP_TICKS:     prdata = 32'(r_timing.gap_ticks);
            default:           prdata = '0;
        endcase
    end

    mbed_front #(
        .NW (NW)
    ) u_front (
        .i_valid         (i_in_valid),
        .o_stall         (o_in_stall),
        .i_raw_levels    (i_raw_levels),
        .i_active_levels (r_active_levels),
        .i_enabled       (enabled),
        .i_q_full        (q_full),
        .o_push          (push),
        .o_push_hit      (push_hit),
        .o_push_n        (push_n)
    );

    mbed_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({push_n, push_hit}),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    mbed_back #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .COUNT_WIDTH (COUNT_WIDTH),
        .NW          (NW)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_timing       (r_timing),
        .i_clr          (cfg_wr && (reg_idx == REG_BUTTON_COUNT)),
        .i_clr_from     (wr_enabled),
        .i_q_empty      (q_empty),
        .i_job_hit      (q_out[LEVEL_W-1:0]),
        .i_job_n        (q_out[QW-1:LEVEL_W]),
        .o_pop          (pop),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_button_index (o_button_index),
        .o_event_code   (o_event_code),
        .o_event_fired  (o_event_fired),
        .o_active_count (o_active_count),
        .o_last         (o_last)
    );

endmodule

[src/mbed_checker.sv]
// ----------------------------------------------------------------------------
// mbed_checker - port-level checks for the multi-button event detector
// Watches the result channel over time and is bound to the top level.
// ----------------------------------------------------------------------------
module mbed_checker
    import mbed_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [2:0]         o_button_index,
    input logic [3:0]         o_event_code,
    input logic               o_event_fired,
    input logic [3:0]         o_active_count,
    input logic               o_last
);

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_button_index)
            && $stable(o_event_code) && $stable(o_event_fired) && $stable(o_last)
            && $stable(o_active_count))
        else $error("stalled result changed");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // The final result of a tick always reports button zero
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last |-> o_button_index == 3'd0)
        else $error("last result not on button zero");

    // Active total rides only on the final result
    a_active_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> o_active_count == 4'd0)
        else $error("active count outside last result");

    // A result after a non-last one that was taken comes from the next lower button
    a_descend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last ##1 o_out_valid
            |-> o_button_index == 3'($past(o_button_index) - 3'd1))
        else $error("buttons not reported in descending order");

endmodule

bind multi_button_event_detector mbed_checker u_mbed_checker (.*);
